@@ rtl/bis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

    // Default capacities
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int MAX_BLOCKS_DEF   = 1024;

    // Field widths
    localparam int VAL_W = 32;
    localparam int BS_W  = 11;

    localparam logic [BS_W-1:0] BS_RESET = 11'd16;

    // Configuration register indexes
    localparam logic CFG_BLOCK_SIZE = 1'b0;
    localparam logic CFG_METHOD     = 1'b1;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_SEARCH = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef logic [9:0]  t_pos;
    typedef logic [11:0] t_cmp;

endpackage

`default_nettype wire

@@ rtl/bis_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bis_ram #(
    parameter int WIDTH = bis_pkg::VAL_W,
    parameter int DEPTH = bis_pkg::MAX_ELEMENTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/block_index_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_func, i_item_value
// out       output     o_out_valid / i_out_stall o_status, o_position, o_comparisons
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Load, clear and ignored items are handled in the cycle they are accepted; the result is registered.
// A search walks the block maxima in the block-max memory, either sequentially or as a
// binary walk, then passes through a setup state when a block is picked and scans that
// block's elements in the element memory.
// Reset is synchronous and active low; the stores need no clearing pass.
// A stalled result holds the output register and holds off the next item.

module block_index_search #(
    parameter int MAX_ELEMENTS = bis_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_BLOCKS   = bis_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input items
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_func,
    input  wire logic signed [bis_pkg::VAL_W-1:0] i_item_value,
    // result items
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_status,
    output logic [9:0]                     o_position,
    output logic [11:0]                    o_comparisons,
    // configuration writes
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [bis_pkg::BS_W-1:0]  i_cfg_data
);

    localparam int VAL_W = bis_pkg::VAL_W;
    localparam int BS_W  = bis_pkg::BS_W;
    // element address / count widths
    localparam int EA_W  = $clog2(MAX_ELEMENTS);
    localparam int EC_W  = $clog2(MAX_ELEMENTS + 1);
    // block address / count widths
    localparam int BA_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BC_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PW    = EC_W + BC_W + BS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_BIN_RD,
        S_BIN_CMP,
        S_SETUP,
        S_SCAN
    } t_state;

    // control state
    t_state             r_state,    n_state;
    logic [BS_W-1:0]    r_bs,       n_bs;
    logic               r_method,   n_method;
    logic [EC_W-1:0]    r_count,    n_count;
    logic [BC_W-1:0]    r_lblk,     n_lblk;
    logic [BS_W-1:0]    r_loff,     n_loff;
    logic               r_out_valid, n_out_valid;
    logic               r_pend,     n_pend;

    // working registers
    logic signed [VAL_W-1:0] r_cur_max, n_cur_max;
    logic signed [VAL_W-1:0] r_tgt,     n_tgt;
    logic [BC_W-1:0]    r_nb,       n_nb;
    logic [BC_W-1:0]    r_wi,       n_wi;
    logic [BC_W-1:0]    r_wpidx,    n_wpidx;
    logic [BC_W-1:0]    r_lo,       n_lo;
    logic [BC_W-1:0]    r_hi,       n_hi;
    logic [BC_W-1:0]    r_mid,      n_mid;
    logic [BC_W-1:0]    r_pick,     n_pick;
    logic [EC_W-1:0]    r_si,       n_si;
    logic [EC_W-1:0]    r_spidx,    n_spidx;
    logic [BS_W-1:0]    r_soff,     n_soff;
    bis_pkg::t_cmp      r_cmp,      n_cmp;
    bis_pkg::t_status   r_status,   n_status;
    bis_pkg::t_pos      r_pos,      n_pos;
    bis_pkg::t_cmp      r_cmpo,     n_cmpo;

    // memory ports
    logic               el_wr_en, el_rd_en;
    logic [EA_W-1:0]    el_wr_addr, el_rd_addr;
    logic [VAL_W-1:0]   el_q;
    logic               bm_wr_en, bm_rd_en;
    logic [BA_W-1:0]    bm_wr_addr, bm_rd_addr;
    logic [VAL_W-1:0]   bm_wr_data, bm_q;

    // helpers
    logic [BS_W-1:0]    bs_eff;
    logic               accept;
    logic               full;
    logic signed [VAL_W-1:0] new_max;
    logic [BS_W-1:0]    loff_inc;
    logic               w_issue;
    logic               s_issue;
    logic [BC_W:0]      mid_sum;
    logic [PW-1:0]      prod;

    assign bs_eff   = (r_bs == '0) ? BS_W'(1) : r_bs;
    assign accept   = i_in_valid && !o_in_stall;
    assign full     = (r_count >= EC_W'(MAX_ELEMENTS)) || (r_lblk >= BC_W'(MAX_BLOCKS));
    assign new_max  = ((r_loff == '0) || (i_item_value > r_cur_max)) ? i_item_value
                                                                     : r_cur_max;
    assign loff_inc = r_loff + BS_W'(1);
    assign w_issue  = r_wi < r_nb;
    assign s_issue  = (r_si < r_count) && (r_soff < bs_eff);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (BC_W + 1)'(1);
    assign prod     = PW'(r_pick) * PW'(bs_eff);

    // take no item while a search runs or a result is stuck in the output register
    assign o_in_stall    = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_comparisons = r_cmpo;

    always_comb begin
        n_state     = r_state;
        n_bs        = r_bs;
        n_method    = r_method;
        n_count     = r_count;
        n_lblk      = r_lblk;
        n_loff      = r_loff;
        n_pend      = r_pend;
        n_cur_max   = r_cur_max;
        n_tgt       = r_tgt;
        n_nb        = r_nb;
        n_wi        = r_wi;
        n_wpidx     = r_wpidx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pick      = r_pick;
        n_si        = r_si;
        n_spidx     = r_spidx;
        n_soff      = r_soff;
        n_cmp       = r_cmp;
        n_status    = r_status;
        n_pos       = r_pos;
        n_cmpo      = r_cmpo;
        // drop the result once it is taken
        n_out_valid = r_out_valid && i_out_stall;

        el_wr_en   = 1'b0;
        el_wr_addr = r_count[EA_W-1:0];
        el_rd_en   = 1'b0;
        el_rd_addr = r_si[EA_W-1:0];
        bm_wr_en   = 1'b0;
        bm_wr_addr = r_lblk[BA_W-1:0];
        bm_wr_data = new_max;
        bm_rd_en   = 1'b0;
        bm_rd_addr = r_wi[BA_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (bis_pkg::t_func'(i_func))
                        bis_pkg::FN_LOAD: begin
                            n_out_valid = 1'b1;
                            n_cmpo      = '0;
                            if (full) begin
                                n_status = bis_pkg::ST_FULL;
                                n_pos    = '0;
                            end else begin
                                el_wr_en  = 1'b1;
                                bm_wr_en  = 1'b1;
                                n_cur_max = new_max;
                                n_count   = r_count + EC_W'(1);
                                // advance the fill position, opening a block when full
                                if (loff_inc == bs_eff) begin
                                    n_loff = '0;
                                    n_lblk = r_lblk + BC_W'(1);
                                end else begin
                                    n_loff = loff_inc;
                                end
                                n_status = bis_pkg::ST_OK;
                                n_pos    = bis_pkg::t_pos'(r_count);
                            end
                        end
                        bis_pkg::FN_SEARCH: begin
                            n_tgt  = i_item_value;
                            n_cmp  = '0;
                            n_pend = 1'b0;
                            // blocks in use: full ones plus a partly filled one
                            n_nb   = r_lblk + BC_W'(r_loff != '0);
                            if (r_method) begin
                                n_lo    = '0;
                                n_hi    = r_lblk + BC_W'(r_loff != '0);
                                n_state = S_BIN_RD;
                            end else begin
                                n_wi    = '0;
                                n_state = S_WALK;
                            end
                        end
                        bis_pkg::FN_CLEAR: begin
                            n_count     = '0;
                            n_lblk      = '0;
                            n_loff      = '0;
                            n_out_valid = 1'b1;
                            n_status    = bis_pkg::ST_OK;
                            n_pos       = '0;
                            n_cmpo      = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = bis_pkg::ST_OK;
                            n_pos       = '0;
                            n_cmpo      = '0;
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (r_pend) begin
                    n_cmp = r_cmp + bis_pkg::t_cmp'(1);
                end
                if (r_pend && ($signed(bm_q) >= r_tgt)) begin
                    n_pick  = r_wpidx;
                    n_pend  = 1'b0;
                    n_state = S_SETUP;
                end else if (!w_issue) begin
                    n_pend      = 1'b0;
                    n_out_valid = 1'b1;
                    n_status    = bis_pkg::ST_MISS;
                    n_pos       = '0;
                    n_cmpo      = n_cmp;
                    n_state     = S_IDLE;
                end else begin
                    // read the next block max while comparing the current one
                    bm_rd_en = 1'b1;
                    n_wpidx  = r_wi;
                    n_wi     = r_wi + BC_W'(1);
                    n_pend   = 1'b1;
                end
            end

            S_BIN_RD: begin
                if (r_lo < r_hi) begin
                    bm_rd_en   = 1'b1;
                    bm_rd_addr = mid_sum[BA_W:1];
                    n_mid      = mid_sum[BC_W:1];
                    n_state    = S_BIN_CMP;
                end else if (r_lo < r_nb) begin
                    n_pick  = r_lo;
                    n_state = S_SETUP;
                end else begin
                    n_out_valid = 1'b1;
                    n_status    = bis_pkg::ST_MISS;
                    n_pos       = '0;
                    n_cmpo      = r_cmp;
                    n_state     = S_IDLE;
                end
            end

            S_BIN_CMP: begin
                n_cmp = r_cmp + bis_pkg::t_cmp'(1);
                if ($signed(bm_q) >= r_tgt) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + BC_W'(1);
                end
                n_state = S_BIN_RD;
            end

            S_SETUP: begin
                n_si    = prod[EC_W-1:0];
                n_soff  = '0;
                n_pend  = 1'b0;
                n_state = S_SCAN;
            end

            S_SCAN: begin
                if (r_pend) begin
                    n_cmp = r_cmp + bis_pkg::t_cmp'(1);
                end
                if (r_pend && (el_q == r_tgt)) begin
                    n_pend      = 1'b0;
                    n_out_valid = 1'b1;
                    n_status    = bis_pkg::ST_OK;
                    n_pos       = bis_pkg::t_pos'(r_spidx);
                    n_cmpo      = n_cmp;
                    n_state     = S_IDLE;
                end else if (!s_issue) begin
                    n_pend      = 1'b0;
                    n_out_valid = 1'b1;
                    n_status    = bis_pkg::ST_MISS;
                    n_pos       = '0;
                    n_cmpo      = n_cmp;
                    n_state     = S_IDLE;
                end else begin
                    el_rd_en = 1'b1;
                    n_spidx  = r_si;
                    n_si     = r_si + EC_W'(1);
                    n_soff   = r_soff + BS_W'(1);
                    n_pend   = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration; a new block size empties the store
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == bis_pkg::CFG_BLOCK_SIZE) begin
                n_bs    = i_cfg_data;
                n_count = '0;
                n_lblk  = '0;
                n_loff  = '0;
            end else begin
                n_method = i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bs        <= bis_pkg::BS_RESET;
            r_method    <= 1'b0;
            r_count     <= '0;
            r_lblk      <= '0;
            r_loff      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bs        <= n_bs;
            r_method    <= n_method;
            r_count     <= n_count;
            r_lblk      <= n_lblk;
            r_loff      <= n_loff;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_cur_max <= n_cur_max;
        r_tgt     <= n_tgt;
        r_nb      <= n_nb;
        r_wi      <= n_wi;
        r_wpidx   <= n_wpidx;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_pick    <= n_pick;
        r_si      <= n_si;
        r_spidx   <= n_spidx;
        r_soff    <= n_soff;
        r_cmp     <= n_cmp;
        r_status  <= n_status;
        r_pos     <= n_pos;
        r_cmpo    <= n_cmpo;
    end

    bis_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ELEMENTS),
        .AW    (EA_W)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (el_wr_en),
        .i_wr_addr (el_wr_addr),
        .i_wr_data (i_item_value),
        .i_rd_en   (el_rd_en),
        .i_rd_addr (el_rd_addr),
        .o_rd_data (el_q)
    );

    bis_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_BLOCKS),
        .AW    (BA_W)
    ) u_bmax_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bm_wr_en),
        .i_wr_addr (bm_wr_addr),
        .i_wr_data (bm_wr_data),
        .i_rd_en   (bm_rd_en),
        .i_rd_addr (bm_rd_addr),
        .o_rd_data (bm_q)
    );

    // a search always ends with the output register free
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |-> !r_out_valid)
        else $error("search finished while output register was occupied");

    // fill offset stays inside the current block
    a_loff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loff < bs_eff)
        else $error("fill offset out of block");

    // binary walk bounds stay ordered and within the used blocks
    a_bin_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIN_RD || r_state == S_BIN_CMP) |-> (r_lo <= r_hi && r_hi <= r_nb))
        else $error("binary walk bounds crossed");

    // element count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= EC_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int VAL_W            = bis_pkg::VAL_W;
    localparam int BS_W             = bis_pkg::BS_W;
    localparam int MAX_ELEMENTS_DEF = bis_pkg::MAX_ELEMENTS_DEF;
    localparam int MAX_BLOCKS_DEF   = bis_pkg::MAX_BLOCKS_DEF;

    // Function code 3 has no operation behind it: the block answers with a plain OK.
    localparam logic [1:0] FN_IGNORED = 2'd3;
    localparam int RANDOM_ITEMS = 600;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        bis_pkg::t_status status;
        bis_pkg::t_pos    position;
        bis_pkg::t_cmp    comparisons;
    } t_outcome;

    typedef struct packed {
        logic [1:0]              fn;
        logic signed [VAL_W-1:0] value;
        logic                    typed;
        t_outcome                want;
    } t_stim_row;

    // Drive every block input to a known value from time zero.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_func = bis_pkg::FN_LOAD;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [1:0]              o_status;
    logic [9:0]              o_position;
    logic [11:0]             o_comparisons;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic                    i_cfg_index = bis_pkg::CFG_BLOCK_SIZE;
    logic [BS_W-1:0]         i_cfg_data = bis_pkg::BS_RESET;

    block_index_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_comparisons (o_comparisons),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the search engine: stores, fill level and registers.
    // Only entries below the fill level are ever read, so the arrays never
    // need clearing.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] shadow_elems     [MAX_ELEMENTS_DEF];
    logic signed [VAL_W-1:0] shadow_block_max [MAX_BLOCKS_DEF];
    int                      shadow_count = 0;
    logic [BS_W-1:0]         shadow_block_size = bis_pkg::BS_RESET;
    logic                    shadow_binary = 1'b0;

    t_outcome  awaited_outcomes [$];
    t_stim_row directed_rows [$];
    t_outcome  oldest;

    int mismatches   = 0;
    int results_seen = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;

    // Apply one item to the shadow engine and return the result it yields.
    function automatic t_outcome index_search_outcome(input logic [1:0] fn,
                                                      input logic signed [VAL_W-1:0] v);
        t_outcome res;
        int       bsz;
        int       idx;
        int       nblk;
        int       probes;
        int       lo;
        int       hi;
        int       mid;
        int       pick;
        int       scan;
        int       stop;
        logic     hit;
        res.status      = bis_pkg::ST_OK;
        res.position    = '0;
        res.comparisons = '0;
        // A block size of zero groups like a block size of one.
        bsz = (shadow_block_size == '0) ? 1 : int'(shadow_block_size);
        case (fn)
            bis_pkg::FN_LOAD: begin
                idx = shadow_count;
                if (idx >= MAX_ELEMENTS_DEF || idx / bsz >= MAX_BLOCKS_DEF) begin
                    res.status = bis_pkg::ST_FULL;
                end else begin
                    shadow_elems[idx] = v;
                    // First element of a block opens its maximum.
                    if (idx % bsz == 0 || v > shadow_block_max[idx / bsz]) begin
                        shadow_block_max[idx / bsz] = v;
                    end
                    shadow_count = idx + 1;
                    res.position = bis_pkg::t_pos'(idx);
                end
            end
            bis_pkg::FN_CLEAR: begin
                shadow_count = 0;
            end
            bis_pkg::FN_SEARCH: begin
                nblk = (shadow_count + bsz - 1) / bsz;
                if (nblk > MAX_BLOCKS_DEF) nblk = MAX_BLOCKS_DEF;
                probes = 0;
                pick   = -1;
                if (!shadow_binary) begin
                    lo = 0;
                    while (pick < 0 && lo < nblk) begin
                        probes++;
                        if (shadow_block_max[lo] >= v) pick = lo;
                        lo++;
                    end
                end else begin
                    // Walk as a bisection even when the maxima do not rise.
                    lo = 0;
                    hi = nblk - 1;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        probes++;
                        if (shadow_block_max[mid] >= v) hi = mid - 1;
                        else lo = mid + 1;
                    end
                    if (lo < nblk) pick = lo;
                end
                res.status = bis_pkg::ST_MISS;
                hit = 1'b0;
                if (pick >= 0) begin
                    scan = pick * bsz;
                    stop = scan + bsz;
                    if (stop > shadow_count) stop = shadow_count;
                    while (!hit && scan < stop && scan < MAX_ELEMENTS_DEF) begin
                        probes++;
                        if (shadow_elems[scan] == v) begin
                            hit = 1'b1;
                            res.status   = bis_pkg::ST_OK;
                            res.position = bis_pkg::t_pos'(scan);
                        end else begin
                            scan++;
                        end
                    end
                end
                res.comparisons = bis_pkg::t_cmp'(probes);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Mostly back-to-back, sometimes a few cycles, now and then a long gap.
    function automatic int pause_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    task automatic add_row(input logic [1:0] fn, input logic signed [VAL_W-1:0] v,
                           input logic typed, input bis_pkg::t_status st, input int pos,
                           input int cmp);
        t_stim_row r;
        r.fn               = fn;
        r.value            = v;
        r.typed            = typed;
        r.want.status      = st;
        r.want.position    = bis_pkg::t_pos'(pos);
        r.want.comparisons = bis_pkg::t_cmp'(cmp);
        directed_rows = {directed_rows, r};
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Offer one item, hold it until accepted, then log what it must produce.
    task automatic offer_item(input logic [1:0] fn, input logic signed [VAL_W-1:0] v,
                              input logic typed, input t_outcome want);
        t_outcome predicted;
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_item_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        predicted = index_search_outcome(fn, v);
        if (typed) predicted = want;
        awaited_outcomes = {awaited_outcomes, predicted};
        if (!tx_quiet) idle_sender(pause_len());
    endtask

    // Leave cfg valid high so back-to-back writes need no extra toggle;
    // the caller drops it after the last write.
    task automatic write_reg(input logic idx, input logic [BS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == bis_pkg::CFG_BLOCK_SIZE) begin
            // A new grouping invalidates the block maxima, so the store empties.
            shadow_block_size = data;
            shadow_count      = 0;
        end else begin
            shadow_binary = data[0];
        end
    endtask

    // Drop valid and wait until every result has drained.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Once, hold off for a long stretch so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!hold_done && results_seen == 300) begin
            hold_left = 400;
            hold_done = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check each accepted result against the oldest entry,
    // then decide the stall for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
                flag_mismatch("result with nothing awaited", o_status, 0);
            end else begin
                oldest = awaited_outcomes.pop_front();
                if (o_status !== oldest.status)
                    flag_mismatch("status", o_status, oldest.status);
                if (o_position !== oldest.position)
                    flag_mismatch("position", o_position, oldest.position);
                if (o_comparisons !== oldest.comparisons)
                    flag_mismatch("comparisons", o_comparisons, oldest.comparisons);
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pause_len();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_stim_row               row;
        t_outcome                no_outcome;
        t_outcome                rejected;
        int                      k;
        int                      random_done;
        int                      phase;
        int                      n_load;
        int                      n_ops;
        int                      roll;
        logic signed [VAL_W-1:0] level;
        logic signed [VAL_W-1:0] target;
        logic signed [VAL_W-1:0] loaded [$];
        logic                    ascending;
        logic                    method_bit;
        logic [BS_W-1:0]         size_pick;

        no_outcome      = '0;
        rejected        = '0;
        rejected.status = bis_pkg::ST_FULL;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset grouping of 16, sequential index walk.
        // Search an empty store: nothing to walk, nothing compared.
        add_row(bis_pkg::FN_SEARCH, 32'sd0,  1'b1, bis_pkg::ST_MISS, 0, 0);
        add_row(bis_pkg::FN_SEARCH, VAL_MIN, 1'b1, bis_pkg::ST_MISS, 0, 0);
        // Unused function code: plain OK, state untouched.
        add_row(FN_IGNORED,         32'sd7,  1'b1, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_CLEAR,  32'sd0,  1'b1, bis_pkg::ST_OK,   0, 0);
        // Loads report their own position.
        add_row(bis_pkg::FN_LOAD,   VAL_MIN, 1'b1, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_LOAD,   VAL_MAX, 1'b1, bis_pkg::ST_OK,   1, 0);
        add_row(bis_pkg::FN_LOAD,   -32'sd1, 1'b1, bis_pkg::ST_OK,   2, 0);
        add_row(bis_pkg::FN_LOAD,   32'sd0,  1'b1, bis_pkg::ST_OK,   3, 0);
        add_row(bis_pkg::FN_LOAD,   32'sd1,  1'b1, bis_pkg::ST_OK,   4, 0);
        add_row(bis_pkg::FN_SEARCH, VAL_MAX, 1'b0, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, VAL_MIN, 1'b0, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, 32'sd0,  1'b0, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, 32'sd1,  1'b0, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, -32'sd1, 1'b0, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, 32'sd2,  1'b0, bis_pkg::ST_OK,   0, 0);
        add_row(FN_IGNORED,         -32'sd1, 1'b1, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, 32'sd1,  1'b0, bis_pkg::ST_OK,   0, 0);
        // Clear empties the store and restarts positions at zero.
        add_row(bis_pkg::FN_CLEAR,  32'sd0,  1'b1, bis_pkg::ST_OK,   0, 0);
        add_row(bis_pkg::FN_SEARCH, 32'sd1,  1'b1, bis_pkg::ST_MISS, 0, 0);
        add_row(bis_pkg::FN_LOAD,   32'sd42, 1'b1, bis_pkg::ST_OK,   0, 0);
        // One index probe plus one element compare.
        add_row(bis_pkg::FN_SEARCH, 32'sd42, 1'b1, bis_pkg::ST_OK,   0, 2);
        foreach (directed_rows[j]) begin
            row = directed_rows[j];
            offer_item(row.fn, row.value, row.typed, row.want);
        end

        // Fill the store to capacity in one large block, then overflow it.
        settle();
        write_reg(bis_pkg::CFG_BLOCK_SIZE, 11'd1024);
        write_reg(bis_pkg::CFG_METHOD, {10'($urandom_range(0, 1023)), 1'b0});
        i_cfg_valid <= 1'b0;
        tx_quiet = 1'b1;
        loaded.delete();
        for (k = 0; k < MAX_ELEMENTS_DEF; k++) begin
            target = $urandom;
            loaded = {loaded, target};
            offer_item(bis_pkg::FN_LOAD, target, 1'b0, no_outcome);
        end
        tx_quiet = 1'b0;
        for (k = 0; k < 3; k++) begin
            offer_item(bis_pkg::FN_LOAD, $urandom, 1'b1, rejected);
        end
        // Search the full store with both index walks.
        for (k = 0; k < 10; k++) begin
            if (k == 5) begin
                settle();
                write_reg(bis_pkg::CFG_METHOD, {10'($urandom_range(0, 1023)), 1'b1});
                i_cfg_valid <= 1'b0;
            end
            roll = $urandom_range(0, 2);
            if (roll == 0) target = loaded[MAX_ELEMENTS_DEF-1];
            else if (roll == 1) target = loaded[$urandom_range(0, MAX_ELEMENTS_DEF-1)];
            else target = $urandom;
            offer_item(bis_pkg::FN_SEARCH, target, 1'b0, no_outcome);
        end

        // Random phases: regroup, load a set, then mostly search it.
        phase       = 0;
        random_done = 0;
        while (random_done < RANDOM_ITEMS) begin
            settle();
            case (phase)
                0: size_pick = '0;
                1: size_pick = 11'd1;
                2: size_pick = 11'd2047;
                3: size_pick = 11'd1024;
                4: size_pick = 11'd2;
                default: begin
                    if ($urandom_range(0, 7) == 0) size_pick = $urandom_range(0, 2047);
                    else size_pick = $urandom_range(1, 24);
                end
            endcase
            method_bit = (phase < 6) ? phase[0] : 1'($urandom_range(0, 1));
            write_reg(bis_pkg::CFG_BLOCK_SIZE, size_pick);
            write_reg(bis_pkg::CFG_METHOD, {10'($urandom_range(0, 1023)), method_bit});
            i_cfg_valid <= 1'b0;

            tx_quiet  = ($urandom_range(0, 5) == 0);
            rx_quiet  = ($urandom_range(0, 5) == 0);
            // Rising values keep the block maxima sorted for the bisection.
            ascending = ($urandom_range(0, 3) != 0);
            level     = $signed($urandom) >>> 1;
            loaded.delete();

            // The regroup must have emptied the store.
            if ($urandom_range(0, 1) == 1) begin
                offer_item(bis_pkg::FN_SEARCH, $urandom, 1'b0, no_outcome);
                random_done++;
            end

            n_load = $urandom_range(1, 40);
            n_ops  = n_load + $urandom_range(10, 30);
            for (k = 0; k < n_ops; k++) begin
                roll = (k < n_load) ? 0 : $urandom_range(1, 100);
                if (roll <= 12) begin
                    if (ascending) begin
                        level  = level + $urandom_range(0, 60);
                        target = level;
                    end else if ($urandom_range(0, 1) == 1) begin
                        target = $urandom;
                    end else begin
                        target = int'($urandom_range(0, 200)) - 100;
                    end
                    loaded = {loaded, target};
                    offer_item(bis_pkg::FN_LOAD, target, 1'b0, no_outcome);
                    random_done++;
                end else if (roll <= 80) begin
                    roll = $urandom_range(0, 99);
                    if (loaded.size() > 0 && roll < 60) begin
                        target = loaded[$urandom_range(0, loaded.size() - 1)];
                    end else if (loaded.size() > 0 && roll < 80) begin
                        target = loaded[$urandom_range(0, loaded.size() - 1)];
                        target = (roll[0]) ? target + 1 : target - 1;
                    end else begin
                        target = $urandom;
                    end
                    offer_item(bis_pkg::FN_SEARCH, target, 1'b0, no_outcome);
                    random_done++;
                end else if (roll <= 86) begin
                    offer_item(FN_IGNORED, $urandom, 1'b0, no_outcome);
                end else if (roll <= 90) begin
                    loaded.delete();
                    offer_item(bis_pkg::FN_CLEAR, $urandom, 1'b0, no_outcome);
                    random_done++;
                end else begin
                    // Noise: any code, any value.
                    offer_item(2'($urandom_range(0, 3)), $urandom, 1'b0, no_outcome);
                    random_done++;
                end
            end
            phase++;
        end

        // Drain, let the clock run on idle, then report.
        settle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && awaited_outcomes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bis_pkg.sv
rtl/bis_ram.sv
rtl/block_index_search.sv
sim/tb.sv
